// ----- rtl/pmc_pkg.sv -----
`timescale 1ns / 1ps

package pmc_pkg;

   // field widths
   localparam int TIME_BITS  = 48;
   localparam int FRAME_BITS = 48;
   localparam int RATE_W     = 18;
   localparam int LAT_W      = 10;
   localparam int CHUNK_W    = 14;
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   // stream packing
   localparam int REQ_FIELDS_W = TIME_BITS + CHUNK_W + 1 + FRAME_BITS;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 + 2 * FRAME_BITS;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_CNT_LSB  = TIME_BITS;
   localparam int REQ_CMP_BIT  = TIME_BITS + CHUNK_W;
   localparam int REQ_POS_LSB  = TIME_BITS + CHUNK_W + 1;
   localparam int RSP_STA_BIT  = 0;
   localparam int RSP_PAU_BIT  = 1;
   localparam int RSP_SUB_LSB  = 2;
   localparam int RSP_AUD_LSB  = 2 + FRAME_BITS;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_START  = KIND_W'(0);
   localparam logic [KIND_W-1:0] KIND_PAUSE  = KIND_W'(1);
   localparam logic [KIND_W-1:0] KIND_RESUME = KIND_W'(2);
   localparam logic [KIND_W-1:0] KIND_RESET  = KIND_W'(3);
   localparam logic [KIND_W-1:0] KIND_SUBMIT = KIND_W'(4);
   localparam logic [KIND_W-1:0] KIND_QUERY  = KIND_W'(5);

   // result status
   localparam logic [STATUS_W-1:0] STATUS_OK     = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] STATUS_IDLE   = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] STATUS_REJECT = STATUS_W'(2);

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_LATENCY     = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_LIMIT = CSR_IDX_W'(2);
   localparam logic [RATE_W-1:0]    RATE_RESET      = RATE_W'(44100);
   localparam logic [LAT_W-1:0]     LAT_RESET       = LAT_W'(100);
   localparam logic [CHUNK_W-1:0]   LIMIT_RESET     = CHUNK_W'(882);

   // time-to-frame datapath
   localparam int MS_PER_S      = 1000;
   localparam int DIG_W         = 16;
   localparam int REM_W         = $clog2(MS_PER_S);
   localparam int PP_COUNT      = (TIME_BITS + DIG_W - 1) / DIG_W;
   localparam int MS_PAD_W      = PP_COUNT * DIG_W;
   localparam int PP_W          = DIG_W + RATE_W;
   localparam int PROD_W        = TIME_BITS + RATE_W;
   localparam int DIV_STEPS     = (PROD_W + DIG_W - 1) / DIG_W;
   localparam int NUM_W         = DIV_STEPS * DIG_W;
   localparam int X_W           = REM_W + DIG_W;
   localparam int RCP_SHIFT     = X_W + REM_W;
   localparam int RCP_W         = X_W + 1;
   localparam int MUL_W         = X_W + RCP_W;
   localparam logic [RCP_W-1:0] RCP =
      RCP_W'(((64'd1 << RCP_SHIFT) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S));
   localparam int QUO_W         = PROD_W - REM_W + 1;
   localparam int SUM_W         = QUO_W + 1;
   localparam int SCALE_STAGES  = 5;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [TIME_BITS-1:0]  now_ms;
      logic [CHUNK_W-1:0]    chunk_frames;
      logic                  write_complete;
      logic [FRAME_BITS-1:0] position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  started;
      logic                  paused;
      logic [FRAME_BITS-1:0] base;
      logic [FRAME_BITS-1:0] submitted;
   } carry_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] t;
      logic [TIME_BITS-1:0] start;
      logic [TIME_BITS-1:0] ptotal;
   } span_type;

   typedef struct packed {
      logic [X_W-1:0]   x;
      logic [DIG_W-1:0] q;
      logic [NUM_W-1:0] num;
      logic [NUM_W-1:0] quo;
   } div_type;

endpackage

// ----- rtl/pmc_state.sv -----
`timescale 1ns / 1ps

module pmc_state (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_load,
   input  pmc_pkg::req_type                  in_data,
   input  logic                              step,
   input  logic [pmc_pkg::CHUNK_W-1:0]       chunk_limit,
   output pmc_pkg::carry_type                snap_carry,
   output pmc_pkg::span_type                 snap_span
);

   pmc_pkg::req_type   in_ff;
   pmc_pkg::carry_type carry_ff, carry_in;
   pmc_pkg::span_type  span_ff, span_in;

   logic                             started_ff, started_in;
   logic                             paused_ff, paused_in;
   logic [pmc_pkg::TIME_BITS-1:0]    start_ff, start_in;
   logic [pmc_pkg::TIME_BITS-1:0]    pause_ff, pause_in;
   logic [pmc_pkg::TIME_BITS-1:0]    ptotal_ff, ptotal_in;
   logic [pmc_pkg::FRAME_BITS-1:0]   base_ff, base_in;
   logic [pmc_pkg::FRAME_BITS-1:0]   sub_ff, sub_in;
   logic [pmc_pkg::STATUS_W-1:0]     status_in;
   logic [pmc_pkg::TIME_BITS-1:0]    now;
   logic [pmc_pkg::TIME_BITS:0]      ptsum;
   logic [pmc_pkg::FRAME_BITS:0]     subsum;

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_ff <= in_data;
      end
      if (step) begin
         carry_ff <= carry_in;
         span_ff  <= span_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         paused_ff  <= 1'b0;
         start_ff   <= '0;
         pause_ff   <= '0;
         ptotal_ff  <= '0;
         base_ff    <= '0;
         sub_ff     <= '0;
      end else if (step) begin
         started_ff <= started_in;
         paused_ff  <= paused_in;
         start_ff   <= start_in;
         pause_ff   <= pause_in;
         ptotal_ff  <= ptotal_in;
         base_ff    <= base_in;
         sub_ff     <= sub_in;
      end
   end

   assign now    = in_ff.now_ms;
   assign ptsum  = {1'b0, ptotal_ff} + {1'b0, now - pause_ff};
   assign subsum = {1'b0, sub_ff} + (pmc_pkg::FRAME_BITS + 1)'(in_ff.chunk_frames);

   always_comb begin
      started_in = started_ff;
      paused_in  = paused_ff;
      start_in   = start_ff;
      pause_in   = pause_ff;
      ptotal_in  = ptotal_ff;
      base_in    = base_ff;
      sub_in     = sub_ff;
      status_in  = pmc_pkg::STATUS_OK;
      case (in_ff.kind)
         pmc_pkg::KIND_START, pmc_pkg::KIND_RESUME: begin
            if (!started_ff) begin
               started_in = 1'b1;
               paused_in  = 1'b0;
               start_in   = now;
               pause_in   = '0;
               ptotal_in  = '0;
            end else if (paused_ff) begin
               if (now > pause_ff) begin
                  ptotal_in = ptsum[pmc_pkg::TIME_BITS] ? '1
                                                         : ptsum[pmc_pkg::TIME_BITS-1:0];
               end
               pause_in  = '0;
               paused_in = 1'b0;
            end
         end
         pmc_pkg::KIND_PAUSE: begin
            if (started_ff && !paused_ff) begin
               pause_in  = now;
               paused_in = 1'b1;
            end
         end
         pmc_pkg::KIND_RESET: begin
            base_in    = in_ff.position;
            sub_in     = in_ff.position;
            start_in   = '0;
            pause_in   = '0;
            ptotal_in  = '0;
            started_in = 1'b0;
            paused_in  = 1'b0;
         end
         pmc_pkg::KIND_SUBMIT: begin
            if (!started_ff || paused_ff || in_ff.chunk_frames == '0) begin
               status_in = pmc_pkg::STATUS_IDLE;
            end else if (in_ff.chunk_frames > chunk_limit || !in_ff.write_complete) begin
               status_in = pmc_pkg::STATUS_REJECT;
            end else begin
               sub_in = subsum[pmc_pkg::FRAME_BITS] ? '1 : subsum[pmc_pkg::FRAME_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   // stopped clock reads as zero elapsed time
   always_comb begin
      span_in.t      = started_in ? (paused_in ? pause_in : now) : '0;
      span_in.start  = started_in ? start_in : '0;
      span_in.ptotal = ptotal_in;
      carry_in.status    = status_in;
      carry_in.started   = started_in;
      carry_in.paused    = paused_in;
      carry_in.base      = base_in;
      carry_in.submitted = sub_in;
   end

   assign snap_carry = carry_ff;
   assign snap_span  = span_ff;

endmodule

// ----- rtl/pmc_scale.sv -----
`timescale 1ns / 1ps

module pmc_scale (
   input  logic                                  clock,
   input  logic [pmc_pkg::SCALE_STAGES-1:0]      load,
   input  pmc_pkg::span_type                     span,
   input  logic [pmc_pkg::LAT_W-1:0]             latency,
   input  logic [pmc_pkg::RATE_W-1:0]            rate,
   output logic [pmc_pkg::PROD_W-1:0]            prod
);

   logic [pmc_pkg::TIME_BITS-1:0] ms_a_ff, ms_a_in;
   logic [pmc_pkg::TIME_BITS-1:0] ptotal_ff;
   logic [pmc_pkg::TIME_BITS-1:0] ms_b_ff, ms_b_in;
   logic [pmc_pkg::TIME_BITS-1:0] ms_c_ff, ms_c_in;
   logic [pmc_pkg::MS_PAD_W-1:0]  ms_pad;
   logic [pmc_pkg::PP_W-1:0]      pp_ff [pmc_pkg::PP_COUNT];
   logic [pmc_pkg::PP_W-1:0]      pp_in [pmc_pkg::PP_COUNT];
   logic [pmc_pkg::PROD_W-1:0]    prod_ff, prod_in;

   assign ms_a_in = (span.t > span.start) ? span.t - span.start : '0;
   assign ms_b_in = (ms_a_ff > ptotal_ff) ? ms_a_ff - ptotal_ff : '0;
   assign ms_c_in = (ms_b_ff > pmc_pkg::TIME_BITS'(latency))
                    ? ms_b_ff - pmc_pkg::TIME_BITS'(latency) : '0;
   assign ms_pad  = pmc_pkg::MS_PAD_W'(ms_c_ff);

   always_comb begin
      for (int j = 0; j < pmc_pkg::PP_COUNT; j++) begin
         pp_in[j] = pmc_pkg::PP_W'(ms_pad[j*pmc_pkg::DIG_W +: pmc_pkg::DIG_W])
                    * pmc_pkg::PP_W'(rate);
      end
   end

   always_comb begin
      prod_in = '0;
      for (int j = 0; j < pmc_pkg::PP_COUNT; j++) begin
         prod_in = prod_in + (pmc_pkg::PROD_W'(pp_ff[j]) << (j * pmc_pkg::DIG_W));
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ms_a_ff   <= ms_a_in;
         ptotal_ff <= span.ptotal;
      end
      if (load[1]) begin
         ms_b_ff <= ms_b_in;
      end
      if (load[2]) begin
         ms_c_ff <= ms_c_in;
      end
      if (load[3]) begin
         for (int j = 0; j < pmc_pkg::PP_COUNT; j++) begin
            pp_ff[j] <= pp_in[j];
         end
      end
      if (load[4]) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/pmc_div_step.sv -----
`timescale 1ns / 1ps

module pmc_div_step (
   input  logic              clock,
   input  logic              load,
   input  pmc_pkg::div_type  prev,
   output pmc_pkg::div_type  cur
);

   pmc_pkg::div_type              cur_ff, cur_in;
   logic [pmc_pkg::REM_W-1:0]     rem;
   logic [pmc_pkg::MUL_W-1:0]     mul;

   // remainder of the previous digit, then next digit by reciprocal
   assign rem = pmc_pkg::REM_W'(prev.x - pmc_pkg::X_W'(prev.q)
                                 * pmc_pkg::X_W'(pmc_pkg::MS_PER_S));

   always_comb begin
      cur_in.x   = {rem, prev.num[pmc_pkg::NUM_W-1 -: pmc_pkg::DIG_W]};
      mul        = pmc_pkg::MUL_W'(cur_in.x) * pmc_pkg::MUL_W'(pmc_pkg::RCP);
      cur_in.q   = pmc_pkg::DIG_W'(mul >> pmc_pkg::RCP_SHIFT);
      cur_in.num = prev.num << pmc_pkg::DIG_W;
      cur_in.quo = (prev.quo << pmc_pkg::DIG_W) | pmc_pkg::NUM_W'(prev.q);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= cur_in;
      end
   end

   assign cur = cur_ff;

endmodule

// ----- rtl/playback_media_clock_top.sv -----
`timescale 1ns / 1ps

// Channel | Dir | Handshake             | Payload
// req     | in  | req_tvalid/req_tready | tuser kind; tdata now_ms, chunk_frames,
//         |     |                       |   write_complete, position
// rsp     | out | rsp_tvalid/rsp_tready | tuser status; tdata is_started, is_paused,
//         |     |                       |   submitted_frames, heard_frames
// csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// One item per cycle until rsp back-pressure fills every stage; the pipeline stages are
// the input register, state update, three clamped subtracts, a split 48x18 multiply
// over two stages, a five-digit divide by 1000, and a final add and cap.
// Reset is synchronous: clears the clock state and loads register defaults; no sweep.
// A stalled result holds in the output register while earlier stages keep filling;
// req_tready drops only when every stage holds an item.

module playback_media_clock_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_ms, chunk_frames, write_complete, position, pad
   input  logic [pmc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind
   input  logic [pmc_pkg::KIND_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // is_started, is_paused, submitted_frames, heard_frames, pad
   output logic [pmc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // status
   output logic [pmc_pkg::STATUS_W-1:0]        rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pmc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pmc_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int SCALE_FIRST = 2;
   localparam int DIV_FIRST   = SCALE_FIRST + pmc_pkg::SCALE_STAGES;
   localparam int OUT_STAGE   = DIV_FIRST + pmc_pkg::DIV_STEPS;
   localparam int NST         = OUT_STAGE + 1;

   logic [NST-1:0]                  vld_ff, vld_in, adv, load, stall;
   logic [pmc_pkg::RATE_W-1:0]      rate_ff;
   logic [pmc_pkg::LAT_W-1:0]       lat_ff;
   logic [pmc_pkg::CHUNK_W-1:0]     limit_ff;
   pmc_pkg::req_type                req;
   pmc_pkg::carry_type              snap_carry;
   pmc_pkg::span_type               snap_span;
   pmc_pkg::carry_type              carry_ff [SCALE_FIRST:NST-1];
   logic [pmc_pkg::PROD_W-1:0]      prod;
   pmc_pkg::div_type                div_w [pmc_pkg::DIV_STEPS+1];
   logic [pmc_pkg::NUM_W-1:0]       quo_full;
   logic [pmc_pkg::SUM_W-1:0]       sum;
   logic [pmc_pkg::FRAME_BITS-1:0]  aud_ff, aud_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= pmc_pkg::RATE_RESET;
         lat_ff   <= pmc_pkg::LAT_RESET;
         limit_ff <= pmc_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pmc_pkg::CSR_SAMPLE_RATE: rate_ff  <= csr_data[pmc_pkg::RATE_W-1:0];
            pmc_pkg::CSR_LATENCY:     lat_ff   <= csr_data[pmc_pkg::LAT_W-1:0];
            pmc_pkg::CSR_CHUNK_LIMIT: limit_ff <= csr_data[pmc_pkg::CHUNK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // pipeline flow: a stage holds only when it and every later stage are full
   always_comb begin
      for (int i = 0; i < NST; i++) begin
         stall[i] = !rsp_tready & (&(vld_ff | ((NST'(1) << i) - NST'(1))));
         adv[i]   = vld_ff[i] & !stall[i];
      end
      load[0] = req_tvalid & req_tready;
      for (int i = 1; i < NST; i++) begin
         load[i] = adv[i-1];
      end
      vld_in = load | (vld_ff & ~adv);
   end

   assign req_tready = !stall[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // unpack
   always_comb begin
      req.kind           = req_tuser;
      req.now_ms         = req_tdata[0 +: pmc_pkg::TIME_BITS];
      req.chunk_frames   = req_tdata[pmc_pkg::REQ_CNT_LSB +: pmc_pkg::CHUNK_W];
      req.write_complete = req_tdata[pmc_pkg::REQ_CMP_BIT];
      req.position       = req_tdata[pmc_pkg::REQ_POS_LSB +: pmc_pkg::FRAME_BITS];
   end

   pmc_state u_state (
      .clock       (clock),
      .reset       (reset),
      .in_load     (load[0]),
      .in_data     (req),
      .step        (load[1]),
      .chunk_limit (limit_ff),
      .snap_carry  (snap_carry),
      .snap_span   (snap_span)
   );

   pmc_scale u_scale (
      .clock   (clock),
      .load    (load[DIV_FIRST-1:SCALE_FIRST]),
      .span    (snap_span),
      .latency (lat_ff),
      .rate    (rate_ff),
      .prod    (prod)
   );

   always_comb begin
      div_w[0].x   = '0;
      div_w[0].q   = '0;
      div_w[0].num = pmc_pkg::NUM_W'(prod);
      div_w[0].quo = '0;
   end

   for (genvar k = 0; k < pmc_pkg::DIV_STEPS; k++) begin : g_div
      pmc_div_step u_div_step (
         .clock (clock),
         .load  (load[DIV_FIRST+k]),
         .prev  (div_w[k]),
         .cur   (div_w[k+1])
      );
   end

   // side fields travel beside the datapath
   always_ff @(posedge clock) begin
      if (load[SCALE_FIRST]) begin
         carry_ff[SCALE_FIRST] <= snap_carry;
      end
      for (int i = SCALE_FIRST + 1; i < NST; i++) begin
         if (load[i]) begin
            carry_ff[i] <= carry_ff[i-1];
         end
      end
   end

   // add base, cap at submitted
   assign quo_full = (div_w[pmc_pkg::DIV_STEPS].quo << pmc_pkg::DIG_W)
                     | pmc_pkg::NUM_W'(div_w[pmc_pkg::DIV_STEPS].q);
   assign sum      = pmc_pkg::SUM_W'(carry_ff[OUT_STAGE-1].base)
                     + pmc_pkg::SUM_W'(quo_full[pmc_pkg::QUO_W-1:0]);
   assign aud_in   = (sum > pmc_pkg::SUM_W'(carry_ff[OUT_STAGE-1].submitted))
                     ? carry_ff[OUT_STAGE-1].submitted : sum[pmc_pkg::FRAME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (load[OUT_STAGE]) begin
         aud_ff <= aud_in;
      end
   end

   assign rsp_tvalid = vld_ff[OUT_STAGE];
   assign rsp_tuser  = carry_ff[OUT_STAGE].status;
   assign rsp_tdata  = pmc_pkg::RSP_DATA_W'({aud_ff,
                                             carry_ff[OUT_STAGE].submitted,
                                             carry_ff[OUT_STAGE].paused,
                                             carry_ff[OUT_STAGE].started});

endmodule

// ----- rtl/pmc_checker.sv -----
`timescale 1ns / 1ps

module pmc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [pmc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic [pmc_pkg::STATUS_W-1:0]      rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_req_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input blocked without a stalled result");

   a_aud_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[pmc_pkg::RSP_AUD_LSB +: pmc_pkg::FRAME_BITS]
                     <= rsp_tdata[pmc_pkg::RSP_SUB_LSB +: pmc_pkg::FRAME_BITS])
      else $error("audible frames above submitted frames");

   a_pause_started: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[pmc_pkg::RSP_PAU_BIT] || rsp_tdata[pmc_pkg::RSP_STA_BIT])
      else $error("paused while stopped");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == pmc_pkg::STATUS_OK || rsp_tuser == pmc_pkg::STATUS_IDLE
                     || rsp_tuser == pmc_pkg::STATUS_REJECT)
      else $error("undefined status");

endmodule

bind playback_media_clock_top pmc_checker u_pmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- sim/tb_playback_media_clock_top.sv -----
`timescale 1ns / 1ps

module tb_playback_media_clock_top;

   localparam logic [pmc_pkg::KIND_W-1:0]     KIND_SPARE_LO = pmc_pkg::KIND_W'(6);
   localparam logic [pmc_pkg::KIND_W-1:0]     KIND_SPARE_HI = pmc_pkg::KIND_W'(7);
   localparam logic [pmc_pkg::FRAME_BITS-1:0] FRAME_TOP     = '1;
   localparam logic [pmc_pkg::TIME_BITS-1:0]  TIME_TOP      = '1;
   localparam int                             DRAIN_CYCLES  = 40;
   localparam int                             PHASE_ITEMS   = 205;

   typedef struct packed {
      logic [pmc_pkg::STATUS_W-1:0]   status;
      logic                           started;
      logic                           paused;
      logic [pmc_pkg::FRAME_BITS-1:0] submitted;
      logic [pmc_pkg::FRAME_BITS-1:0] audible;
   } position_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [pmc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [pmc_pkg::KIND_W-1:0]     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [pmc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [pmc_pkg::STATUS_W-1:0]   rsp_tuser;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [pmc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [pmc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   pmc_pkg::req_type event_q[$];
   position_type     position_q[$];
   pmc_pkg::req_type req_cur;
   int               req_taken = 0;
   int               req_sent = 0;
   int               req_gap = 0;
   int               rsp_stall = 0;
   int               errors = 0;
   bit               idle_on = 1'b1;
   logic [pmc_pkg::TIME_BITS-1:0] cur_ms = pmc_pkg::TIME_BITS'(10000);

   // predictor state and register copies
   logic                           trk_started;
   logic                           trk_paused;
   logic [pmc_pkg::TIME_BITS-1:0]  trk_start_ms;
   logic [pmc_pkg::TIME_BITS-1:0]  trk_pause_ms;
   logic [pmc_pkg::TIME_BITS-1:0]  trk_paused_ms;
   logic [pmc_pkg::FRAME_BITS-1:0] trk_base;
   logic [pmc_pkg::FRAME_BITS-1:0] trk_submitted;
   logic [pmc_pkg::RATE_W-1:0]     cfg_rate = pmc_pkg::RATE_RESET;
   logic [pmc_pkg::LAT_W-1:0]      cfg_latency = pmc_pkg::LAT_RESET;
   logic [pmc_pkg::CHUNK_W-1:0]    cfg_limit = pmc_pkg::LIMIT_RESET;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   playback_media_clock_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      trk_started   = 1'b0;
      trk_paused    = 1'b0;
      trk_start_ms  = '0;
      trk_pause_ms  = '0;
      trk_paused_ms = '0;
      trk_base      = '0;
      trk_submitted = '0;
   end

   function automatic logic [63:0] cap48(input logic [63:0] v);
      return (v > 64'(FRAME_TOP)) ? 64'(FRAME_TOP) : v;
   endfunction

   function automatic position_type step_media_clock(input pmc_pkg::req_type ev);
      position_type res;
      logic [63:0]  t;
      logic [63:0]  ms;
      logic [63:0]  frames;
      res.status = pmc_pkg::STATUS_OK;
      case (ev.kind)
         pmc_pkg::KIND_START, pmc_pkg::KIND_RESUME: begin
            if (!trk_started) begin
               trk_started   = 1'b1;
               trk_paused    = 1'b0;
               trk_start_ms  = ev.now_ms;
               trk_pause_ms  = '0;
               trk_paused_ms = '0;
            end else if (trk_paused) begin
               if (ev.now_ms > trk_pause_ms)
                  trk_paused_ms = pmc_pkg::TIME_BITS'(cap48(64'(trk_paused_ms)
                                                   + 64'(ev.now_ms - trk_pause_ms)));
               trk_pause_ms = '0;
               trk_paused   = 1'b0;
            end
         end
         pmc_pkg::KIND_PAUSE: begin
            if (trk_started && !trk_paused) begin
               trk_pause_ms = ev.now_ms;
               trk_paused   = 1'b1;
            end
         end
         pmc_pkg::KIND_RESET: begin
            trk_base      = ev.position;
            trk_submitted = ev.position;
            trk_start_ms  = '0;
            trk_pause_ms  = '0;
            trk_paused_ms = '0;
            trk_started   = 1'b0;
            trk_paused    = 1'b0;
         end
         pmc_pkg::KIND_SUBMIT: begin
            if (!trk_started || trk_paused || ev.chunk_frames == '0)
               res.status = pmc_pkg::STATUS_IDLE;
            else if (ev.chunk_frames > cfg_limit || !ev.write_complete)
               res.status = pmc_pkg::STATUS_REJECT;
            else
               trk_submitted = pmc_pkg::FRAME_BITS'(cap48(64'(trk_submitted)
                                                          + 64'(ev.chunk_frames)));
         end
         default: ;
      endcase
      res.started   = trk_started;
      res.paused    = trk_paused;
      res.submitted = trk_submitted;
      if (!trk_started) begin
         res.audible = trk_base;
      end else begin
         t  = trk_paused ? 64'(trk_pause_ms) : 64'(ev.now_ms);
         ms = (t > 64'(trk_start_ms)) ? t - 64'(trk_start_ms) : 64'd0;
         ms = (ms > 64'(trk_paused_ms)) ? ms - 64'(trk_paused_ms) : 64'd0;
         ms = (ms > 64'(cfg_latency)) ? ms - 64'(cfg_latency) : 64'd0;
         frames = cap48((ms / 64'(pmc_pkg::MS_PER_S)) * 64'(cfg_rate));
         frames = cap48(frames + ((ms % 64'(pmc_pkg::MS_PER_S)) * 64'(cfg_rate))
                                 / 64'(pmc_pkg::MS_PER_S));
         frames = cap48(frames + 64'(trk_base));
         res.audible = (frames > 64'(trk_submitted)) ? trk_submitted
                                                     : frames[pmc_pkg::FRAME_BITS-1:0];
      end
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (errors < 100)
         $display("%0t: mismatch on %s: got %0h, want %0h", $time, field, got, want);
      errors++;
   endtask

   task automatic add_event(input logic [pmc_pkg::KIND_W-1:0] kind,
                            input logic [pmc_pkg::TIME_BITS-1:0] now,
                            input logic [pmc_pkg::CHUNK_W-1:0] count, input logic complete,
                            input logic [pmc_pkg::FRAME_BITS-1:0] pos);
      pmc_pkg::req_type ev;
      ev.kind           = kind;
      ev.now_ms         = now;
      ev.chunk_frames   = count;
      ev.write_complete = complete;
      ev.position       = pos;
      event_q.push_back(ev);
   endtask

   task automatic add_random_event();
      int                             pick;
      int                             hi;
      logic [pmc_pkg::KIND_W-1:0]     kind;
      logic [pmc_pkg::CHUNK_W-1:0]    cnt;
      logic [pmc_pkg::FRAME_BITS-1:0] pos;
      pick = $urandom_range(0, 99);
      if (pick < 4)
         kind = pmc_pkg::KIND_RESET;
      else if (pick < 12)
         kind = pmc_pkg::KIND_START;
      else if (pick < 20)
         kind = pmc_pkg::KIND_PAUSE;
      else if (pick < 28)
         kind = pmc_pkg::KIND_RESUME;
      else if (pick < 65)
         kind = pmc_pkg::KIND_SUBMIT;
      else if (pick < 95)
         kind = pmc_pkg::KIND_QUERY;
      else if (pick < 98)
         kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
      else
         kind = pmc_pkg::KIND_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 3)
         cur_ms = pmc_pkg::TIME_BITS'({$urandom(), $urandom()});
      else if (pick < 6)
         cur_ms = (cur_ms > pmc_pkg::TIME_BITS'(2000))
                  ? cur_ms - pmc_pkg::TIME_BITS'($urandom_range(1, 2000)) : '0;
      else
         cur_ms = cur_ms + pmc_pkg::TIME_BITS'($urandom_range(0, 40));
      hi   = (cfg_limit == '0) ? 1 : int'(cfg_limit);
      pick = $urandom_range(0, 99);
      if (pick < 5)
         cnt = '0;
      else if (pick < 15)
         cnt = pmc_pkg::CHUNK_W'($urandom());
      else
         cnt = pmc_pkg::CHUNK_W'($urandom_range(1, hi));
      pick = $urandom_range(0, 99);
      if (kind != pmc_pkg::KIND_RESET || pick >= 80)
         pos = pmc_pkg::FRAME_BITS'({$urandom(), $urandom()});
      else if (pick < 50)
         pos = pmc_pkg::FRAME_BITS'($urandom_range(0, 65535));
      else
         pos = FRAME_TOP - pmc_pkg::FRAME_BITS'($urandom_range(0, 100000));
      add_event(kind, cur_ms, cnt, $urandom_range(0, 9) != 0, pos);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (event_q.size() != 0 || req_tvalid || position_q.size() != 0);
   endtask

   task automatic csr_write(input logic [pmc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pmc_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      case (idx)
         pmc_pkg::CSR_SAMPLE_RATE: cfg_rate    = val[pmc_pkg::RATE_W-1:0];
         pmc_pkg::CSR_LATENCY:     cfg_latency = val[pmc_pkg::LAT_W-1:0];
         pmc_pkg::CSR_CHUNK_LIMIT: cfg_limit   = val[pmc_pkg::CHUNK_W-1:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(input logic [pmc_pkg::CSR_DATA_W-1:0] rate,
                            input logic [pmc_pkg::CSR_DATA_W-1:0] lat,
                            input logic [pmc_pkg::CSR_DATA_W-1:0] limit, input bit idle,
                            input int n);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      idle_on = idle;
      csr_write(pmc_pkg::CSR_SAMPLE_RATE, rate);
      csr_write(pmc_pkg::CSR_LATENCY, lat);
      csr_write(pmc_pkg::CSR_CHUNK_LIMIT, limit);
      @(negedge clock);
      csr_valid <= 1'b0;
      for (int i = 0; i < n; i++)
         add_random_event();
   endtask

   // request driver
   always @(negedge clock) begin
      logic                           next_valid;
      logic [pmc_pkg::REQ_DATA_W-1:0] word;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_tvalid && req_taken != req_sent) begin
            req_sent   = req_taken;
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (event_q.size() != 0) begin
               req_cur = event_q.pop_front();
               word = '0;
               word[pmc_pkg::TIME_BITS-1:0]                     = req_cur.now_ms;
               word[pmc_pkg::REQ_CNT_LSB +: pmc_pkg::CHUNK_W]    = req_cur.chunk_frames;
               word[pmc_pkg::REQ_CMP_BIT]                       = req_cur.write_complete;
               word[pmc_pkg::REQ_POS_LSB +: pmc_pkg::FRAME_BITS] = req_cur.position;
               req_tdata  <= word;
               req_tuser  <= req_cur.kind;
               next_valid = 1'b1;
               if (idle_on && $urandom_range(0, 9) == 0)
                  req_gap = $urandom_range(1, 16);
            end
         end
      end
      req_tvalid <= next_valid;
   end

   // result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_stall = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      position_type seen;
      position_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status    = rsp_tuser;
            seen.started   = rsp_tdata[pmc_pkg::RSP_STA_BIT];
            seen.paused    = rsp_tdata[pmc_pkg::RSP_PAU_BIT];
            seen.submitted = rsp_tdata[pmc_pkg::RSP_SUB_LSB +: pmc_pkg::FRAME_BITS];
            seen.audible   = rsp_tdata[pmc_pkg::RSP_AUD_LSB +: pmc_pkg::FRAME_BITS];
            if (position_q.size() == 0) begin
               report_mismatch("item with no expectation", 64'(seen.audible), 64'd0);
            end else begin
               want = position_q.pop_front();
               if (seen.status !== want.status)
                  report_mismatch("status", 64'(seen.status), 64'(want.status));
               if (seen.started !== want.started)
                  report_mismatch("is_started", 64'(seen.started), 64'(want.started));
               if (seen.paused !== want.paused)
                  report_mismatch("is_paused", 64'(seen.paused), 64'(want.paused));
               if (seen.submitted !== want.submitted)
                  report_mismatch("submitted_frames", 64'(seen.submitted), 64'(want.submitted));
               if (seen.audible !== want.audible)
                  report_mismatch("heard_frames", 64'(seen.audible), 64'(want.audible));
            end
         end
         if (req_tvalid && req_tready) begin
            position_q.push_back(step_media_clock(req_cur));
            req_taken++;
         end
      end
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_event(pmc_pkg::KIND_QUERY,  pmc_pkg::TIME_BITS'(0),    '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_SUBMIT, pmc_pkg::TIME_BITS'(10),
                pmc_pkg::CHUNK_W'(882), 1'b1, '0);
      add_event(pmc_pkg::KIND_PAUSE,  pmc_pkg::TIME_BITS'(20),   '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_RESUME, pmc_pkg::TIME_BITS'(1000), '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_QUERY,  pmc_pkg::TIME_BITS'(500),  '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_START,  pmc_pkg::TIME_BITS'(1100), '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_SUBMIT, pmc_pkg::TIME_BITS'(1200), '0, 1'b1, '0);
      add_event(pmc_pkg::KIND_SUBMIT, pmc_pkg::TIME_BITS'(1210),
                pmc_pkg::CHUNK_W'(883), 1'b1, '0);
      add_event(pmc_pkg::KIND_SUBMIT, pmc_pkg::TIME_BITS'(1220),
                pmc_pkg::CHUNK_W'(882), 1'b0, '0);
      add_event(pmc_pkg::KIND_SUBMIT, pmc_pkg::TIME_BITS'(1230),
                pmc_pkg::CHUNK_W'(882), 1'b1, '0);
      add_event(pmc_pkg::KIND_QUERY,  pmc_pkg::TIME_BITS'(1500), '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_PAUSE,  pmc_pkg::TIME_BITS'(1600), '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_PAUSE,  pmc_pkg::TIME_BITS'(1700), '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_SUBMIT, pmc_pkg::TIME_BITS'(1710),
                pmc_pkg::CHUNK_W'(10), 1'b1, '0);
      add_event(pmc_pkg::KIND_QUERY,  pmc_pkg::TIME_BITS'(5000), '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_RESUME, pmc_pkg::TIME_BITS'(1400), '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_PAUSE,  pmc_pkg::TIME_BITS'(1800), '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_START,  pmc_pkg::TIME_BITS'(2200), '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_RESUME, pmc_pkg::TIME_BITS'(2300), '0, 1'b0, '0);
      add_event(KIND_SPARE_LO, pmc_pkg::TIME_BITS'(2400), '1, 1'b1, FRAME_TOP);
      add_event(KIND_SPARE_HI, TIME_TOP, '1, 1'b1, FRAME_TOP);
      add_event(pmc_pkg::KIND_RESET,  pmc_pkg::TIME_BITS'(2500), '0, 1'b0,
                FRAME_TOP - pmc_pkg::FRAME_BITS'(5));
      add_event(pmc_pkg::KIND_START,  pmc_pkg::TIME_BITS'(0),    '0, 1'b0, '0);
      add_event(pmc_pkg::KIND_SUBMIT, pmc_pkg::TIME_BITS'(100),
                pmc_pkg::CHUNK_W'(882), 1'b1, '0);
      add_event(pmc_pkg::KIND_QUERY,  TIME_TOP,                  '0, 1'b0, '0);

      run_phase(pmc_pkg::CSR_DATA_W'(44100),  pmc_pkg::CSR_DATA_W'(100),
                pmc_pkg::CSR_DATA_W'(882),   1'b1, PHASE_ITEMS);
      run_phase(pmc_pkg::CSR_DATA_W'(192000), pmc_pkg::CSR_DATA_W'(1000),
                pmc_pkg::CSR_DATA_W'(8192),  1'b1, PHASE_ITEMS);
      run_phase(pmc_pkg::CSR_DATA_W'(1),      pmc_pkg::CSR_DATA_W'(1),
                pmc_pkg::CSR_DATA_W'(1),     1'b1, PHASE_ITEMS);
      run_phase(pmc_pkg::CSR_DATA_W'(0),      pmc_pkg::CSR_DATA_W'(0),
                pmc_pkg::CSR_DATA_W'(0),     1'b1, PHASE_ITEMS);
      run_phase(pmc_pkg::CSR_DATA_W'(262143), pmc_pkg::CSR_DATA_W'(1023),
                pmc_pkg::CSR_DATA_W'(16383), 1'b0, PHASE_ITEMS);
      run_phase(pmc_pkg::CSR_DATA_W'(48000),  pmc_pkg::CSR_DATA_W'(20),
                pmc_pkg::CSR_DATA_W'(480),   1'b1, PHASE_ITEMS);
      run_phase(pmc_pkg::CSR_DATA_W'(8000),   pmc_pkg::CSR_DATA_W'(500),
                pmc_pkg::CSR_DATA_W'(4096),  1'b0, PHASE_ITEMS);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
